### hdl/sskbm_pkg.sv
// shared types and constants for the two-wire display and key bus master
// no dependencies; imported by every module of the block
`default_nettype none

package sskbm_pkg;

  localparam logic [1:0] OP_DIGIT  = 2'd0;
  localparam logic [1:0] OP_BRIGHT = 2'd1;
  localparam logic [1:0] OP_SCAN   = 2'd2;

  localparam logic [1:0] GM_LOOKUP = 2'd0;
  localparam logic [1:0] GM_POINT  = 2'd1;
  localparam logic [1:0] GM_RAW    = 2'd2;

  localparam logic [7:0] CMD_DATA    = 8'h40;
  localparam logic [7:0] CMD_ADDR    = 8'hC0;
  localparam logic [7:0] CMD_READ    = 8'h42;
  localparam logic [7:0] CMD_CTRL    = 8'h80;
  localparam logic [7:0] CTRL_ON     = 8'h08;
  localparam logic [7:0] SEG_POINT   = 8'h80;
  localparam logic [7:0] GLYPH_BLANK = 8'd16;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [7:0] SEG_TABLE [17] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'h00
  };

  typedef struct packed {
    logic       request_valid;
    logic [1:0] opcode;
    logic [2:0] position;
    logic [7:0] glyph_value;
    logic [1:0] glyph_mode;
    logic [3:0] duty_level;
    logic       data_pin_sample;
  } in_item_t;

  typedef struct packed {
    logic       clock_pin;
    logic       data_pin;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] key_code;
    logic       key_changed;
    logic       ack_missing;
  } out_item_t;

  // request decode handed from the message builder to the engine
  typedef struct packed {
    logic       start;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } msg_t;

endpackage

`default_nettype wire

### hdl/sskbm_msg_build.sv
// request decode: validity check and the command, address and segment bytes
// depends on sskbm_pkg
`default_nettype none

module sskbm_msg_build #(
  parameter int DIGIT_COUNT = 6
) (
  input  sskbm_pkg::in_item_t item,
  output sskbm_pkg::msg_t     msg
);
  import sskbm_pkg::*;

  logic [7:0] seg;
  logic [7:0] lut;
  logic       pos_bad;

  assign lut     = (item.glyph_value <= GLYPH_BLANK) ? SEG_TABLE[item.glyph_value[4:0]] : 8'h00;
  assign pos_bad = (item.opcode == OP_DIGIT) && (item.position >= 3'(DIGIT_COUNT));

  always_comb begin
    case (item.glyph_mode)
      GM_RAW:   seg = item.glyph_value;
      GM_POINT: seg = lut | SEG_POINT;
      default:  seg = lut;
    endcase
  end

  always_comb begin
    msg.start = item.request_valid && (item.opcode == OP_DIGIT || item.opcode == OP_BRIGHT ||
                                       item.opcode == OP_SCAN) && !pos_bad;
    msg.byte1 = CMD_ADDR + {5'd0, item.position};
    msg.byte2 = seg;
    case (item.opcode)
      OP_DIGIT:  msg.byte0 = CMD_DATA;
      OP_BRIGHT: msg.byte0 = (item.duty_level == 4'd0) ? CMD_CTRL :
                             (CMD_CTRL | CTRL_ON | {4'd0, item.duty_level - 4'd1});
      default:   msg.byte0 = CMD_READ;
    endcase
  end

endmodule

`default_nettype wire

### hdl/sskbm_engine.sv
// bus sequencer: one tick of the pin waveform per transfer, holds all transaction state
// depends on sskbm_pkg
`default_nettype none

module sskbm_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  sskbm_pkg::in_item_t  item,
  input  sskbm_pkg::msg_t      msg,
  input  logic [15:0]          timeout,
  output sskbm_pkg::out_item_t result
);
  import sskbm_pkg::*;

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_START1  = 12'b0000_0000_0010,
    PH_START2  = 12'b0000_0000_0100,
    PH_WLO     = 12'b0000_0000_1000,
    PH_WHI     = 12'b0000_0001_0000,
    PH_ACKREL  = 12'b0000_0010_0000,
    PH_ACKPOLL = 12'b0000_0100_0000,
    PH_RLO     = 12'b0000_1000_0000,
    PH_RHI     = 12'b0001_0000_0000,
    PH_STOP1   = 12'b0010_0000_0000,
    PH_STOP2   = 12'b0100_0000_0000,
    PH_STOP3   = 12'b1000_0000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] wait_count, wait_count_next;
  logic [7:0]  previous_key, previous_key_next;
  logic [1:0]  pending_opcode, pending_opcode_next;
  logic        ack_flag, ack_flag_next;
  logic [7:0]  message_bytes [3];

  logic [1:0]  bi_inc;
  logic [15:0] wait_inc;
  logic [15:0] limit;
  logic [7:0]  load_sel;
  logic [7:0]  code;
  logic        poll_out;
  logic        finish;
  logic        accept;
  logic        clk_o, dat_o, drv_o, done_o, changed_o;

  assign accept   = (phase == PH_IDLE) && msg.start;
  assign bi_inc   = byte_index + 2'd1;
  assign wait_inc = (wait_count == 16'hFFFF) ? wait_count : wait_count + 16'd1;
  assign limit    = (timeout == 16'd0) ? 16'd1 : timeout;
  assign poll_out = item.data_pin_sample && (wait_inc >= limit);
  assign finish   = !item.data_pin_sample || poll_out;
  assign code     = ~shift_byte;

  always_comb begin
    case (byte_index)
      2'd0:    load_sel = message_bytes[0];
      2'd1:    load_sel = message_bytes[1];
      default: load_sel = message_bytes[2];
    endcase
  end

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    byte_index_next     = byte_index;
    shift_byte_next     = shift_byte;
    wait_count_next     = wait_count;
    previous_key_next   = previous_key;
    pending_opcode_next = pending_opcode;
    ack_flag_next       = ack_flag;
    clk_o               = 1'b1;
    dat_o               = 1'b1;
    drv_o               = 1'b1;
    done_o              = 1'b0;
    changed_o           = 1'b0;
    if (accept) begin
      // first start tick shows idle levels
      pending_opcode_next = item.opcode;
      ack_flag_next       = 1'b0;
      byte_index_next     = 2'd0;
      phase_next          = PH_START2;
    end else begin
      case (phase)
        PH_START1: begin
          phase_next = PH_START2;
        end
        PH_START2: begin
          dat_o           = 1'b0;
          shift_byte_next = load_sel;
          bit_count_next  = 3'd0;
          phase_next      = PH_WLO;
        end
        PH_WLO: begin
          clk_o      = 1'b0;
          dat_o      = shift_byte[0];
          phase_next = PH_WHI;
        end
        PH_WHI: begin
          dat_o           = shift_byte[0];
          shift_byte_next = {1'b0, shift_byte[7:1]};
          if (bit_count == 3'd7) begin
            phase_next = PH_ACKREL;
          end else begin
            bit_count_next = bit_count + 3'd1;
            phase_next     = PH_WLO;
          end
        end
        PH_ACKREL: begin
          clk_o           = 1'b0;
          dat_o           = 1'b0;
          drv_o           = 1'b0;
          wait_count_next = 16'd0;
          phase_next      = PH_ACKPOLL;
        end
        PH_ACKPOLL: begin
          if (item.data_pin_sample) begin
            wait_count_next = wait_inc;
          end
          if (poll_out) begin
            ack_flag_next = 1'b1;
          end
          if (finish) begin
            dat_o           = 1'b0;
            byte_index_next = bi_inc;
            if (pending_opcode == OP_SCAN) begin
              if (bi_inc == 2'd1) begin
                shift_byte_next = 8'd0;
                bit_count_next  = 3'd0;
                phase_next      = PH_RLO;
              end else begin
                phase_next = PH_STOP1;
              end
            end else if (pending_opcode == OP_DIGIT && bi_inc == 2'd2) begin
              shift_byte_next = message_bytes[2];
              bit_count_next  = 3'd0;
              phase_next      = PH_WLO;
            end else begin
              phase_next = PH_STOP1;
            end
          end else begin
            clk_o = 1'b0;
            dat_o = 1'b0;
            drv_o = 1'b0;
          end
        end
        PH_RLO: begin
          clk_o      = 1'b0;
          dat_o      = 1'b0;
          drv_o      = 1'b0;
          phase_next = PH_RHI;
        end
        PH_RHI: begin
          dat_o           = 1'b0;
          drv_o           = 1'b0;
          shift_byte_next = {item.data_pin_sample, shift_byte[7:1]};
          if (bit_count == 3'd7) begin
            phase_next = PH_ACKREL;
          end else begin
            bit_count_next = bit_count + 3'd1;
          end
        end
        PH_STOP1: begin
          clk_o      = 1'b0;
          dat_o      = 1'b0;
          phase_next = PH_STOP2;
        end
        PH_STOP2: begin
          dat_o      = 1'b0;
          phase_next = PH_STOP3;
        end
        PH_STOP3: begin
          if (pending_opcode == OP_DIGIT && byte_index == 2'd1) begin
            phase_next = PH_START1;
          end else begin
            if (pending_opcode == OP_SCAN) begin
              changed_o         = (code != previous_key);
              previous_key_next = code;
            end
            done_o     = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.clock_pin   = clk_o;
    result.data_pin    = dat_o;
    result.data_drive  = drv_o;
    result.busy_res    = (phase_next != PH_IDLE);
    result.done_res    = done_o;
    result.key_code    = previous_key_next;
    result.key_changed = changed_o;
    result.ack_missing = ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= 3'd0;
      byte_index     <= 2'd0;
      shift_byte     <= 8'd0;
      wait_count     <= 16'd0;
      previous_key   <= 8'd0;
      pending_opcode <= OP_DIGIT;
      ack_flag       <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      byte_index     <= byte_index_next;
      shift_byte     <= shift_byte_next;
      wait_count     <= wait_count_next;
      previous_key   <= previous_key_next;
      pending_opcode <= pending_opcode_next;
      ack_flag       <= ack_flag_next;
    end
  end

  // message bytes, loaded when a request starts
  always_ff @(posedge clk) begin
    if (fire && accept) begin
      message_bytes[0] <= msg.byte0;
      message_bytes[1] <= msg.byte1;
      message_bytes[2] <= msg.byte2;
    end
  end

endmodule

`default_nettype wire

### hdl/seven_segment_key_bus_master.sv
// Two-wire display and key bus master. Every input transfer is one delay tick of the
// bus waveform and yields exactly one result transfer with the pin levels and status
// for that tick. One tick is taken per clock cycle sustained while the output is not
// stalled; a tick passes through an input register and one pass of the sequencer into
// the result register, so a result is offered once its tick has reached the result
// register, and a stalled output holds the input side. The acknowledge timeout
// register is written on the cfg port (reset 1000 ticks, zero acts as one). No clearing
// pass after reset. Depends on sskbm_pkg, sskbm_msg_build and sskbm_engine.
`default_nettype none

module seven_segment_key_bus_master #(
  parameter int DIGIT_COUNT = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sskbm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sskbm_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import sskbm_pkg::*;

  in_item_t  in_q;
  logic      in_full;
  logic      fire;
  logic [15:0] ack_timeout_ticks;
  msg_t      msg;
  out_item_t result;

  assign fire      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  sskbm_msg_build #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_msg (
    .item(in_q),
    .msg (msg)
  );

  sskbm_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_q),
    .msg    (msg),
    .timeout(ack_timeout_ticks),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("tick processed but no result offered");

  a_change_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.key_changed |-> out_item.done_res)
    else $error("key change flagged outside a done tick");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done tick still reports busy");

  a_released_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.data_drive |-> !out_item.data_pin && out_item.busy_res)
    else $error("released data line outside a transaction");

endmodule

`default_nettype wire
